// File: hdl/wfs_pkg.sv
`default_nettype none

package wfs_pkg;

	// Queue between the byte front end and the field parser
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = QPTR_W + 1;

	localparam int MAX_VARINT_BYTES = 10;

	// Wire types that carry a body the parser understands
	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIXED64 = 3'd1;
	localparam logic [2:0] WT_LEN     = 3'd2;
	localparam logic [2:0] WT_FIXED32 = 3'd5;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_ZERO     = 3'd1,
		ST_BAD_WT   = 3'd2,
		ST_LONG     = 3'd3,
		ST_TRUNC    = 3'd4,
		ST_LEN_BIG  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		PH_TAG    = 3'd0,
		PH_VARINT = 3'd1,
		PH_FIXED  = 3'd2,
		PH_LENGTH = 3'd3,
		PH_SKIP   = 3'd4
	} phase_t;

	// One classified byte as it sits in the queue
	typedef struct packed {
		logic [7:0] data;
		logic       cont;
		logic       last;
	} byte_item_t;

	// Head of the queue as the parser sees it
	typedef struct packed {
		logic       valid;
		byte_item_t item;
	} q_head_t;

endpackage

`default_nettype wire

// File: hdl/wfs_front.sv
`default_nettype none

module wfs_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output wfs_pkg::q_head_t      head,
	input  wire logic             pop
);

	wfs_pkg::byte_item_t                mem_q [wfs_pkg::QDEPTH];
	logic [wfs_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [wfs_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [wfs_pkg::QCNT_W-1:0]         cnt_q;
	wfs_pkg::byte_item_t                cls;
	logic                               push;
	logic                               pop_ok;

	// classify: the continuation flag rides along with the byte
	always_comb begin
		cls.data = data_byte;
		cls.cont = data_byte[7];
		cls.last = last_byte;
	end

	assign in_ready = (cnt_q != wfs_pkg::QCNT_W'(wfs_pkg::QDEPTH));
	assign push     = in_valid && in_ready;
	assign pop_ok   = pop && (cnt_q != '0);

	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop_ok})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= wfs_pkg::QCNT_W'(wfs_pkg::QDEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: hdl/wfs_back.sv
`default_nettype none

module wfs_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire wfs_pkg::q_head_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [28:0]           field_id,
	output logic [2:0]            wire_type,
	output logic [63:0]           field_value,
	output logic [30:0]           payload_length,
	output logic [2:0]            status,
	output logic                  end_of_buffer
);

	wfs_pkg::phase_t  phase_q, phase_nxt;
	logic [63:0]      accum_q, accum_nxt;
	logic [3:0]       cnt_q, cnt_nxt;
	logic [28:0]      num_q, num_nxt;
	logic [2:0]       wt_q, wt_nxt;
	logic [30:0]      skip_q, skip_nxt;
	logic             err_q, err_nxt;

	logic             out_valid_q;
	logic [28:0]      num_out_q;
	logic [2:0]       wt_out_q;
	logic [63:0]      val_out_q;
	logic [30:0]      len_out_q;
	wfs_pkg::status_t st_out_q;
	logic             eob_out_q;

	logic             fire;
	logic             last;
	logic [63:0]      vshift, fshift, vacc, facc;
	logic [3:0]       cnt_inc;
	logic             vdone, vlong;
	logic [28:0]      tag_num;
	logic [2:0]       tag_wt;
	logic [31:0]      len32;
	logic [30:0]      skip_dec;

	logic             f_go;
	logic [28:0]      f_num;
	logic [2:0]       f_wt;
	wfs_pkg::status_t f_st;
	logic             ok_go;
	logic [63:0]      ok_val;
	logic [30:0]      ok_len;
	logic             clear;

	assign fire = head.valid && (!out_valid_q || out_ready);
	assign pop  = fire;
	assign last = head.item.last;

	// place the 7 payload bits of a varint byte at 7 * count
	always_comb begin
		vshift = '0;
		for (int k = 0; k < wfs_pkg::MAX_VARINT_BYTES; k++) begin
			if (cnt_q == 4'(k)) begin
				vshift = 64'(head.item.data[6:0]) << (7 * k);
			end
		end
	end

	assign fshift   = 64'(head.item.data) << {cnt_q[2:0], 3'b000};
	assign vacc     = accum_q | vshift;
	assign facc     = accum_q | fshift;
	assign cnt_inc  = cnt_q + 4'd1;
	assign vdone    = !head.item.cont;
	assign vlong    = head.item.cont && (cnt_q == 4'(wfs_pkg::MAX_VARINT_BYTES - 1));
	assign tag_num  = vacc[31:3];
	assign tag_wt   = vacc[2:0];
	assign len32    = vacc[31:0];
	assign skip_dec = (skip_q != '0) ? skip_q - 31'd1 : '0;

	always_comb begin
		phase_nxt = phase_q;
		accum_nxt = accum_q;
		cnt_nxt   = cnt_q;
		num_nxt   = num_q;
		wt_nxt    = wt_q;
		skip_nxt  = skip_q;
		err_nxt   = err_q;
		f_go      = 1'b0;
		f_num     = num_q;
		f_wt      = wt_q;
		f_st      = wfs_pkg::ST_TRUNC;
		ok_go     = 1'b0;
		ok_val    = '0;
		ok_len    = '0;
		clear     = 1'b0;

		if (err_q) begin
			// drop bytes until the end of the buffer
			if (last) begin
				clear   = 1'b1;
				err_nxt = 1'b0;
			end
		end else begin
			case (phase_q)
				wfs_pkg::PH_TAG: begin
					accum_nxt = vacc;
					cnt_nxt   = cnt_inc;
					if (!vdone) begin
						if (vlong || last) begin
							f_go  = 1'b1;
							f_num = '0;
							f_wt  = '0;
							f_st  = vlong ? wfs_pkg::ST_LONG : wfs_pkg::ST_TRUNC;
						end
					end else if (tag_num == '0) begin
						f_go  = 1'b1;
						f_num = '0;
						f_wt  = tag_wt;
						f_st  = wfs_pkg::ST_ZERO;
					end else if (!(tag_wt inside {wfs_pkg::WT_VARINT, wfs_pkg::WT_FIXED64,
							wfs_pkg::WT_LEN, wfs_pkg::WT_FIXED32})) begin
						f_go  = 1'b1;
						f_num = tag_num;
						f_wt  = tag_wt;
						f_st  = wfs_pkg::ST_BAD_WT;
					end else begin
						num_nxt   = tag_num;
						wt_nxt    = tag_wt;
						accum_nxt = '0;
						cnt_nxt   = '0;
						case (tag_wt)
							wfs_pkg::WT_VARINT: phase_nxt = wfs_pkg::PH_VARINT;
							wfs_pkg::WT_LEN:    phase_nxt = wfs_pkg::PH_LENGTH;
							default:            phase_nxt = wfs_pkg::PH_FIXED;
						endcase
						if (last) begin
							f_go  = 1'b1;
							f_num = tag_num;
							f_wt  = tag_wt;
							f_st  = wfs_pkg::ST_TRUNC;
						end
					end
				end
				wfs_pkg::PH_VARINT: begin
					accum_nxt = vacc;
					cnt_nxt   = cnt_inc;
					if (!vdone) begin
						if (vlong || last) begin
							f_go = 1'b1;
							f_st = vlong ? wfs_pkg::ST_LONG : wfs_pkg::ST_TRUNC;
						end
					end else begin
						ok_go  = 1'b1;
						ok_val = vacc;
					end
				end
				wfs_pkg::PH_FIXED: begin
					accum_nxt = facc;
					cnt_nxt   = cnt_inc;
					if ((wt_q == wfs_pkg::WT_FIXED64) ? (cnt_inc >= 4'd8) : (cnt_inc >= 4'd4)) begin
						ok_go  = 1'b1;
						ok_val = facc;
					end else if (last) begin
						f_go = 1'b1;
						f_st = wfs_pkg::ST_TRUNC;
					end
				end
				wfs_pkg::PH_LENGTH: begin
					accum_nxt = vacc;
					cnt_nxt   = cnt_inc;
					if (!vdone) begin
						if (vlong || last) begin
							f_go = 1'b1;
							f_st = vlong ? wfs_pkg::ST_LONG : wfs_pkg::ST_TRUNC;
						end
					end else if (len32[31]) begin
						f_go = 1'b1;
						f_st = wfs_pkg::ST_LEN_BIG;
					end else if (len32 == '0) begin
						ok_go = 1'b1;
					end else begin
						accum_nxt = 64'(len32);
						cnt_nxt   = '0;
						skip_nxt  = len32[30:0];
						phase_nxt = wfs_pkg::PH_SKIP;
						if (last) begin
							f_go = 1'b1;
							f_st = wfs_pkg::ST_TRUNC;
						end
					end
				end
				wfs_pkg::PH_SKIP: begin
					skip_nxt = skip_dec;
					if (skip_dec == '0) begin
						ok_go  = 1'b1;
						ok_len = accum_q[30:0];
					end else if (last) begin
						f_go = 1'b1;
						f_st = wfs_pkg::ST_TRUNC;
					end
				end
				default: begin
					clear = 1'b1;
				end
			endcase
		end

		if (f_go) begin
			clear   = 1'b1;
			err_nxt = !last;
		end
		if (ok_go) begin
			clear = 1'b1;
		end
		if (clear) begin
			phase_nxt = wfs_pkg::PH_TAG;
			accum_nxt = '0;
			cnt_nxt   = '0;
			num_nxt   = '0;
			wt_nxt    = '0;
			skip_nxt  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= wfs_pkg::PH_TAG;
			accum_q     <= '0;
			cnt_q       <= '0;
			num_q       <= '0;
			wt_q        <= '0;
			skip_q      <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q     <= phase_nxt;
				accum_q     <= accum_nxt;
				cnt_q       <= cnt_nxt;
				num_q       <= num_nxt;
				wt_q        <= wt_nxt;
				skip_q      <= skip_nxt;
				err_q       <= err_nxt;
				out_valid_q <= f_go || ok_go;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (f_go || ok_go)) begin
			num_out_q <= f_go ? f_num : num_q;
			wt_out_q  <= f_go ? f_wt : wt_q;
			val_out_q <= f_go ? '0 : ok_val;
			len_out_q <= f_go ? '0 : ok_len;
			st_out_q  <= f_go ? f_st : wfs_pkg::ST_OK;
			eob_out_q <= last;
		end
	end

	assign out_valid      = out_valid_q;
	assign field_id       = num_out_q;
	assign wire_type      = wt_out_q;
	assign field_value    = val_out_q;
	assign payload_length = len_out_q;
	assign status         = st_out_q;
	assign end_of_buffer  = eob_out_q;

	a_hold_clean: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> (phase_q == wfs_pkg::PH_TAG) && (cnt_q == '0) && (skip_q == '0))
		else $error("field state left behind while holding after an error");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (st_out_q != wfs_pkg::ST_OK) |-> (val_out_q == '0) && (len_out_q == '0))
		else $error("error result carries value or length");

	a_ok_num: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (st_out_q == wfs_pkg::ST_OK) |-> (num_out_q != '0))
		else $error("completed field with field number zero");

	a_trunc_eob: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (st_out_q == wfs_pkg::ST_TRUNC) |-> eob_out_q)
		else $error("truncation reported away from the last byte");

endmodule

`default_nettype wire

// File: hdl/wire_field_scanner.sv
// Wire-format field scanner.
// Input channel (in_valid/in_ready): one buffer byte per item on data_byte,
// with last_byte high on the final byte of the buffer.
// Output channel (out_valid/out_ready): one item per completed field or per
// error: field_id, wire_type, field_value (varint or fixed body),
// payload_length (length-delimited bodies, whose payload bytes are skipped),
// status and end_of_buffer.
// Throughput: one byte per cycle while results are taken. The parser retires
// one byte each cycle unless a result waits on out_ready; its next-state
// logic is a single pass over a 64-bit accumulator. The byte completing a
// field is written into the 4-entry byte queue; the parser registers the
// result in its output register as it pops that byte.
// After an error the scanner emits nothing until the last byte of the buffer;
// every last byte returns it to reading a tag.
// Reset (arst_n low) empties the queue, drops any pending result and clears
// the parser state; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register while
// the queue keeps taking bytes; in_ready falls only once the queue is full.
`default_nettype none

module wire_field_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [28:0]      field_id,
	output logic [2:0]       wire_type,
	output logic [63:0]      field_value,
	output logic [30:0]      payload_length,
	output logic [2:0]       status,
	output logic             end_of_buffer
);

	wfs_pkg::q_head_t head;
	logic             pop;

	// Front: take bytes, flag continuation, queue them
	wfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.head      (head),
		.pop       (pop)
	);

	// Back: walk tag and body, register one result per field
	wfs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.field_id       (field_id),
		.wire_type      (wire_type),
		.field_value    (field_value),
		.payload_length (payload_length),
		.status         (status),
		.end_of_buffer  (end_of_buffer)
	);

endmodule

`default_nettype wire
